// ===== hdl/eba_pkg.sv =====
// ----------------------------------------------------------------------------
// eba_pkg: shared types and constants of the eight-bit ALU
// Opcodes, flag and result structs, and the decimal adjust tables.
// ----------------------------------------------------------------------------
package eba_pkg;

   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_ADC   = 5'd1,
      OP_SUB   = 5'd2,
      OP_SBC   = 5'd3,
      OP_AND   = 5'd4,
      OP_OR    = 5'd5,
      OP_XOR   = 5'd6,
      OP_CP    = 5'd7,
      OP_INC   = 5'd8,
      OP_DEC   = 5'd9,
      OP_RLC   = 5'd10,
      OP_RL    = 5'd11,
      OP_RRC   = 5'd12,
      OP_RR    = 5'd13,
      OP_SLA   = 5'd14,
      OP_SRA   = 5'd15,
      OP_SRL   = 5'd16,
      OP_SWAP  = 5'd17,
      OP_BIT   = 5'd18,
      OP_SET   = 5'd19,
      OP_RES   = 5'd20,
      OP_CPL   = 5'd21,
      OP_DAA   = 5'd22,
      OP_ADD16 = 5'd23
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_ADD  = 2'd1,
      KIND_SUB  = 2'd2
   } kind_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [15:0] result;
      flags_type   flags;
      logic        writes_back;
      logic        adjust_error;
      kind_type    kind;
   } alu_out_type;

   // One decimal adjust row: carry in, high nibble range, half carry in,
   // low nibble range, correction and carry out.
   typedef struct packed {
      logic       cy;
      logic [3:0] hi_lo;
      logic [3:0] hi_hi;
      logic       h;
      logic [3:0] lo_lo;
      logic [3:0] lo_hi;
      logic [7:0] delta;
      logic       new_cy;
   } daa_row_type;

   localparam int AddRows = 9;
   localparam int SubRows = 4;

   localparam daa_row_type ADD_ROWS [AddRows] = '{
      '{1'b0, 4'h0, 4'h9, 1'b0, 4'h0, 4'h9, 8'h00, 1'b0},
      '{1'b0, 4'h0, 4'h8, 1'b0, 4'ha, 4'hf, 8'h06, 1'b0},
      '{1'b0, 4'h0, 4'h9, 1'b1, 4'h0, 4'h3, 8'h06, 1'b0},
      '{1'b0, 4'ha, 4'hf, 1'b0, 4'h0, 4'h9, 8'h60, 1'b1},
      '{1'b0, 4'h9, 4'hf, 1'b0, 4'ha, 4'hf, 8'h66, 1'b1},
      '{1'b0, 4'ha, 4'hf, 1'b1, 4'h0, 4'h3, 8'h66, 1'b1},
      '{1'b1, 4'h0, 4'h2, 1'b0, 4'h0, 4'h9, 8'h60, 1'b1},
      '{1'b1, 4'h0, 4'h2, 1'b0, 4'ha, 4'hf, 8'h66, 1'b1},
      '{1'b1, 4'h0, 4'h3, 1'b1, 4'h0, 4'h3, 8'h66, 1'b1}
   };

   localparam daa_row_type SUB_ROWS [SubRows] = '{
      '{1'b0, 4'h0, 4'h9, 1'b0, 4'h0, 4'h9, 8'h00, 1'b0},
      '{1'b0, 4'h0, 4'h8, 1'b1, 4'h6, 4'hf, 8'hfa, 1'b0},
      '{1'b1, 4'h7, 4'hf, 1'b0, 4'h0, 4'h9, 8'ha0, 1'b1},
      '{1'b1, 4'h6, 4'hf, 1'b1, 4'h6, 4'hf, 8'h9a, 1'b1}
   };

endpackage

// ===== hdl/eight_bit_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags: eight-bit ALU with Z/N/H/CY flags and DAA
// Registered single-pass ALU: input register, one ALU stage, result register.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req_stall is low and returns
// one response per request, in order. A request waits in the input register
// and then moves into the result register, which offers its response. The
// sustained rate, one request per cycle without rsp_stall, is set by the single
// ALU stage between the two registers. The flag register and the kind of the
// last add or subtract advance as each request moves into the result
// register, so a request always sees the flags left by the one before it,
// even when both are in flight. While rsp_stall holds the result register, a
// request already in the input register waits and req_stall rises; the input
// register is free again in the cycle the response is taken. No setup is
// needed after reset: flags and last kind clear to zero.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_opcode,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic [2:0]  req_bit_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result,
   output logic        rsp_flag_zero,
   output logic        rsp_flag_subtract,
   output logic        rsp_flag_half,
   output logic        rsp_flag_carry,
   output logic        rsp_writes_back,
   output logic        rsp_adjust_error
);

   // Input register.
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [4:0]  in_opcode_ff;
   logic [15:0] in_operand_a_ff;
   logic [15:0] in_operand_b_ff;
   logic [2:0]  in_bit_index_ff;

   // Result register.
   logic                 out_valid_ff;
   logic                 out_valid_in;
   eba_pkg::alu_out_type out_ff;

   // Architectural state.
   eba_pkg::flags_type flags_ff;
   eba_pkg::kind_type  kind_ff;

   eba_pkg::alu_out_type alu_out;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   // The result register can load when empty or when its response leaves now.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   // Hold requests off only while the input register is full and blocked.
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   eba_alu u_alu (
      .opcode    (in_opcode_ff),
      .operand_a (in_operand_a_ff),
      .operand_b (in_operand_b_ff),
      .bit_index (in_bit_index_ff),
      .flags     (flags_ff),
      .last_kind (kind_ff),
      .alu_out   (alu_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         kind_ff      <= eba_pkg::KIND_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // Advance the flags with the request that moves into the result register.
         if (advance) begin
            flags_ff <= alu_out.flags;
            kind_ff  <= alu_out.kind;
         end
      end
   end

   // Payload registers: the input side loads on take, the result side on advance; both hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff    <= req_opcode;
         in_operand_a_ff <= req_operand_a;
         in_operand_b_ff <= req_operand_b;
         in_bit_index_ff <= req_bit_index;
      end
      if (advance) begin
         out_ff <= alu_out;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result        = out_ff.result;
   assign rsp_flag_zero     = out_ff.flags.z;
   assign rsp_flag_subtract = out_ff.flags.n;
   assign rsp_flag_half     = out_ff.flags.h;
   assign rsp_flag_carry    = out_ff.flags.c;
   assign rsp_writes_back   = out_ff.writes_back;
   assign rsp_adjust_error  = out_ff.adjust_error;

   // The flags shown with a response are the live flags until the next one.
   a_rsp_flags_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_ff.flags == flags_ff))
      else $error("response flags differ from flag register");

   // Flag state moves only when a request advances.
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags_ff) && $stable(kind_ff))
      else $error("flag state changed without an advancing request");

   // A failed decimal adjust never writes back and returns zero.
   a_adjust_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_adjust_error) |-> (!rsp_writes_back && rsp_result == 16'd0))
      else $error("adjust error with write-back or nonzero result");

   // A blocked input register keeps its request for the next cycle.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("blocked request lost from input register");

endmodule

// ===== hdl/eba_alu.sv =====
// ----------------------------------------------------------------------------
// eba_alu: combinational ALU datapath
// Computes result, new flags, write-back and adjust error for one request.
// ----------------------------------------------------------------------------
module eba_alu (
   input  logic [4:0]           opcode,
   input  logic [15:0]          operand_a,
   input  logic [15:0]          operand_b,
   input  logic [2:0]           bit_index,
   input  eba_pkg::flags_type   flags,
   input  eba_pkg::kind_type    last_kind,
   output eba_pkg::alu_out_type alu_out
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic [7:0]  mask;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  nib5;
   logic [8:0]  dif9;
   logic [4:0]  nibd5;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic        daa_ok;
   logic [7:0]  daa_res;
   logic        daa_cy;

   assign a    = operand_a[7:0];
   assign b    = operand_b[7:0];
   assign mask = 8'd1 << bit_index;

   // Carry in only for the with-carry forms.
   assign cin = ((opcode == eba_pkg::OP_ADC) || (opcode == eba_pkg::OP_SBC)) ? flags.c : 1'b0;

   assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
   assign nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
   assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cin};
   assign nibd5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
   assign sum17 = {1'b0, operand_a} + {1'b0, operand_b};
   assign sum13 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

   // First matching row of the table chosen by the last arithmetic kind.
   always_comb begin
      daa_ok  = 1'b0;
      daa_res = 8'd0;
      daa_cy  = 1'b0;
      if (last_kind == eba_pkg::KIND_ADD) begin
         for (int r = 0; r < eba_pkg::AddRows; r++) begin
            if (!daa_ok && flags.c == eba_pkg::ADD_ROWS[r].cy
                && a[7:4] >= eba_pkg::ADD_ROWS[r].hi_lo && a[7:4] <= eba_pkg::ADD_ROWS[r].hi_hi
                && flags.h == eba_pkg::ADD_ROWS[r].h
                && a[3:0] >= eba_pkg::ADD_ROWS[r].lo_lo
                && a[3:0] <= eba_pkg::ADD_ROWS[r].lo_hi) begin
               daa_ok  = 1'b1;
               daa_res = a + eba_pkg::ADD_ROWS[r].delta;
               daa_cy  = eba_pkg::ADD_ROWS[r].new_cy;
            end
         end
      end else if (last_kind == eba_pkg::KIND_SUB) begin
         for (int r = 0; r < eba_pkg::SubRows; r++) begin
            if (!daa_ok && flags.c == eba_pkg::SUB_ROWS[r].cy
                && a[7:4] >= eba_pkg::SUB_ROWS[r].hi_lo && a[7:4] <= eba_pkg::SUB_ROWS[r].hi_hi
                && flags.h == eba_pkg::SUB_ROWS[r].h
                && a[3:0] >= eba_pkg::SUB_ROWS[r].lo_lo
                && a[3:0] <= eba_pkg::SUB_ROWS[r].lo_hi) begin
               daa_ok  = 1'b1;
               daa_res = a + eba_pkg::SUB_ROWS[r].delta;
               daa_cy  = eba_pkg::SUB_ROWS[r].new_cy;
            end
         end
      end
   end

   always_comb begin
      logic [7:0] r8;
      logic       t;
      r8 = 8'd0;
      t  = 1'b0;
      alu_out.result       = 16'd0;
      alu_out.flags        = flags;
      alu_out.writes_back  = 1'b1;
      alu_out.adjust_error = 1'b0;
      alu_out.kind         = eba_pkg::KIND_NONE;
      unique case (eba_pkg::op_type'(opcode)) inside
         eba_pkg::OP_ADD, eba_pkg::OP_ADC: begin
            r8 = sum9[7:0];
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b0, h: nib5[4], c: sum9[8]};
            alu_out.kind  = eba_pkg::KIND_ADD;
         end
         eba_pkg::OP_SUB, eba_pkg::OP_SBC, eba_pkg::OP_CP: begin
            r8 = dif9[7:0];
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b1, h: nibd5[4], c: dif9[8]};
            if (opcode == eba_pkg::OP_CP) begin
               r8 = 8'd0;
               alu_out.writes_back = 1'b0;
            end else begin
               alu_out.kind = eba_pkg::KIND_SUB;
            end
         end
         eba_pkg::OP_AND: begin
            r8 = a & b;
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         eba_pkg::OP_OR: begin
            r8 = a | b;
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         eba_pkg::OP_XOR: begin
            r8 = a ^ b;
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         eba_pkg::OP_INC: begin
            r8 = a + 8'd1;
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b0, h: (r8[3:0] == 4'd0), c: flags.c};
         end
         eba_pkg::OP_DEC: begin
            r8 = a - 8'd1;
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'd0), c: flags.c};
         end
         eba_pkg::OP_RLC, eba_pkg::OP_RL, eba_pkg::OP_RRC, eba_pkg::OP_RR,
         eba_pkg::OP_SLA, eba_pkg::OP_SRA, eba_pkg::OP_SRL, eba_pkg::OP_SWAP: begin
            case (eba_pkg::op_type'(opcode))
               eba_pkg::OP_RLC: begin r8 = {a[6:0], a[7]};    t = a[7]; end
               eba_pkg::OP_RL:  begin r8 = {a[6:0], flags.c}; t = a[7]; end
               eba_pkg::OP_RRC: begin r8 = {a[0], a[7:1]};    t = a[0]; end
               eba_pkg::OP_RR:  begin r8 = {flags.c, a[7:1]}; t = a[0]; end
               eba_pkg::OP_SLA: begin r8 = {a[6:0], 1'b0};    t = a[7]; end
               eba_pkg::OP_SRA: begin r8 = {a[7], a[7:1]};    t = a[0]; end
               eba_pkg::OP_SRL: begin r8 = {1'b0, a[7:1]};    t = a[0]; end
               default:         begin r8 = {a[3:0], a[7:4]};  t = 1'b0; end
            endcase
            alu_out.flags = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: t};
         end
         eba_pkg::OP_BIT: begin
            alu_out.flags = '{z: ((a & mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags.c};
            alu_out.writes_back = 1'b0;
         end
         eba_pkg::OP_SET: r8 = a | mask;
         eba_pkg::OP_RES: r8 = a & ~mask;
         eba_pkg::OP_CPL: begin
            r8 = ~a;
            alu_out.flags = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
         end
         eba_pkg::OP_DAA: begin
            if (daa_ok) begin
               r8 = daa_res;
               alu_out.flags = '{z: (daa_res == 8'd0), n: flags.n, h: 1'b0, c: daa_cy};
            end else begin
               alu_out.writes_back  = 1'b0;
               alu_out.adjust_error = 1'b1;
            end
         end
         eba_pkg::OP_ADD16: ;
         default: alu_out.writes_back = 1'b0;
      endcase
      if (opcode == eba_pkg::OP_ADD16) begin
         alu_out.result = sum17[15:0];
         alu_out.flags  = '{z: flags.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end else begin
         alu_out.result = {8'd0, r8};
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the eight-bit ALU with flags
// Directed and random requests go through a valid/stall driver. A monitor
// predicts each accepted request, flags and last add/subtract kind included,
// and checks every response in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RandomItems   = 1900;
   localparam int QuietTail     = 150;   // requests left when idling stops
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 8;
   localparam int MaxReports    = 10;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
   } alu_req_type;

   typedef struct packed {
      logic [15:0]        result;
      eba_pkg::flags_type flags;
      logic               writes_back;
      logic               adjust_error;
   } alu_rsp_type;

   // Decimal adjust corrections, one table per kind of the previous operation.
   localparam eba_pkg::daa_row_type BCD_ADD_FIX [9] = '{
      '{1'b0, 4'h0, 4'h9, 1'b0, 4'h0, 4'h9, 8'h00, 1'b0},
      '{1'b0, 4'h0, 4'h8, 1'b0, 4'ha, 4'hf, 8'h06, 1'b0},
      '{1'b0, 4'h0, 4'h9, 1'b1, 4'h0, 4'h3, 8'h06, 1'b0},
      '{1'b0, 4'ha, 4'hf, 1'b0, 4'h0, 4'h9, 8'h60, 1'b1},
      '{1'b0, 4'h9, 4'hf, 1'b0, 4'ha, 4'hf, 8'h66, 1'b1},
      '{1'b0, 4'ha, 4'hf, 1'b1, 4'h0, 4'h3, 8'h66, 1'b1},
      '{1'b1, 4'h0, 4'h2, 1'b0, 4'h0, 4'h9, 8'h60, 1'b1},
      '{1'b1, 4'h0, 4'h2, 1'b0, 4'ha, 4'hf, 8'h66, 1'b1},
      '{1'b1, 4'h0, 4'h3, 1'b1, 4'h0, 4'h3, 8'h66, 1'b1}
   };

   localparam eba_pkg::daa_row_type BCD_SUB_FIX [4] = '{
      '{1'b0, 4'h0, 4'h9, 1'b0, 4'h0, 4'h9, 8'h00, 1'b0},
      '{1'b0, 4'h0, 4'h8, 1'b1, 4'h6, 4'hf, 8'hfa, 1'b0},
      '{1'b1, 4'h7, 4'hf, 1'b0, 4'h0, 4'h9, 8'ha0, 1'b1},
      '{1'b1, 4'h6, 4'hf, 1'b1, 4'h6, 4'hf, 8'h9a, 1'b1}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_opcode = '0;
   logic [15:0] req_operand_a = '0;
   logic [15:0] req_operand_b = '0;
   logic [2:0]  req_bit_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_result;
   logic        rsp_flag_zero;
   logic        rsp_flag_subtract;
   logic        rsp_flag_half;
   logic        rsp_flag_carry;
   logic        rsp_writes_back;
   logic        rsp_adjust_error;

   // Predicted state of the ALU.
   eba_pkg::flags_type acc_flags = '0;
   eba_pkg::kind_type  last_kind = eba_pkg::KIND_NONE;

   alu_req_type req_pend_q [$];
   alu_rsp_type alu_expect_q [$];
   alu_req_type next_req;
   alu_rsp_type seen_rsp;
   alu_rsp_type want_rsp;
   logic        req_taken = 1'b0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          idle_cycles = 0;
   int          fail_count = 0;

   eight_bit_alu_with_flags dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_bit_index     (req_bit_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result        (rsp_result),
      .rsp_flag_zero     (rsp_flag_zero),
      .rsp_flag_subtract (rsp_flag_subtract),
      .rsp_flag_half     (rsp_flag_half),
      .rsp_flag_carry    (rsp_flag_carry),
      .rsp_writes_back   (rsp_writes_back),
      .rsp_adjust_error  (rsp_adjust_error)
   );

   always #1 clock = ~clock;

   function automatic logic bcd_row_hits(eba_pkg::daa_row_type row, logic [7:0] acc,
                                         logic cy, logic h);
      return row.cy == cy && row.h == h &&
             acc[7:4] >= row.hi_lo && acc[7:4] <= row.hi_hi &&
             acc[3:0] >= row.lo_lo && acc[3:0] <= row.lo_hi;
   endfunction

   // Compute the response of one request and advance the flags and the kind
   // of the last arithmetic operation, as the ALU does.
   function automatic alu_rsp_type alu_predict(alu_req_type rq);
      logic [7:0]           a;
      logic [7:0]           b;
      logic                 cy;
      logic                 c;
      logic                 shift_out;
      logic                 found;
      logic [8:0]           sum9;
      logic [16:0]          sum17;
      logic [12:0]          low12;
      logic [7:0]           r8;
      eba_pkg::daa_row_type fix;
      eba_pkg::flags_type   f;
      eba_pkg::kind_type    kind;
      alu_rsp_type          rp;
      a         = rq.operand_a[7:0];
      b         = rq.operand_b[7:0];
      cy        = acc_flags.c;
      f         = acc_flags;
      kind      = eba_pkg::KIND_NONE;
      rp        = '0;
      rp.writes_back = 1'b1;
      r8        = 8'h00;
      shift_out = 1'b0;
      found     = 1'b0;
      fix       = '0;
      case (rq.opcode)
         eba_pkg::OP_ADD, eba_pkg::OP_ADC: begin
            c    = (rq.opcode == eba_pkg::OP_ADC) ? cy : 1'b0;
            sum9 = {1'b0, a} + {1'b0, b} + {8'h00, c};
            r8   = sum9[7:0];
            f.z  = (r8 == 8'h00);
            f.n  = 1'b0;
            f.h  = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c}) > 5'h0f;
            f.c  = sum9[8];
            kind = eba_pkg::KIND_ADD;
         end
         eba_pkg::OP_SUB, eba_pkg::OP_SBC, eba_pkg::OP_CP: begin
            c   = (rq.opcode == eba_pkg::OP_SBC) ? cy : 1'b0;
            r8  = a - b - {7'h00, c};
            f.z = (r8 == 8'h00);
            f.n = 1'b1;
            f.h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, c});
            f.c = {1'b0, a} < ({1'b0, b} + {8'h00, c});
            if (rq.opcode == eba_pkg::OP_CP) begin
               r8 = 8'h00;
               rp.writes_back = 1'b0;
            end else begin
               kind = eba_pkg::KIND_SUB;
            end
         end
         eba_pkg::OP_AND: begin
            r8 = a & b;
            f  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         eba_pkg::OP_OR: begin
            r8 = a | b;
            f  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         eba_pkg::OP_XOR: begin
            r8 = a ^ b;
            f  = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         eba_pkg::OP_INC: begin
            r8 = a + 8'h01;
            f  = '{z: (r8 == 8'h00), n: 1'b0, h: (r8[3:0] == 4'h0), c: cy};
         end
         eba_pkg::OP_DEC: begin
            r8 = a - 8'h01;
            f  = '{z: (r8 == 8'h00), n: 1'b1, h: (a[3:0] == 4'h0), c: cy};
         end
         eba_pkg::OP_RLC, eba_pkg::OP_RL, eba_pkg::OP_RRC, eba_pkg::OP_RR,
         eba_pkg::OP_SLA, eba_pkg::OP_SRA, eba_pkg::OP_SRL, eba_pkg::OP_SWAP: begin
            case (rq.opcode)
               eba_pkg::OP_RLC: begin r8 = {a[6:0], a[7]}; shift_out = a[7]; end
               eba_pkg::OP_RL:  begin r8 = {a[6:0], cy};   shift_out = a[7]; end
               eba_pkg::OP_RRC: begin r8 = {a[0], a[7:1]}; shift_out = a[0]; end
               eba_pkg::OP_RR:  begin r8 = {cy, a[7:1]};   shift_out = a[0]; end
               eba_pkg::OP_SLA: begin r8 = {a[6:0], 1'b0}; shift_out = a[7]; end
               eba_pkg::OP_SRA: begin r8 = {a[7], a[7:1]}; shift_out = a[0]; end
               eba_pkg::OP_SRL: begin r8 = {1'b0, a[7:1]}; shift_out = a[0]; end
               default: r8 = {a[3:0], a[7:4]};
            endcase
            f = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: shift_out};
         end
         eba_pkg::OP_BIT: begin
            f = '{z: !a[rq.bit_index], n: 1'b0, h: 1'b1, c: cy};
            rp.writes_back = 1'b0;
         end
         eba_pkg::OP_SET: r8 = a | (8'h01 << rq.bit_index);
         eba_pkg::OP_RES: r8 = a & ~(8'h01 << rq.bit_index);
         eba_pkg::OP_CPL: begin
            r8  = ~a;
            f.n = 1'b1;
            f.h = 1'b1;
         end
         eba_pkg::OP_DAA: begin
            if (last_kind == eba_pkg::KIND_ADD) begin
               for (int i = 0; i < 9; i++) begin
                  if (!found && bcd_row_hits(BCD_ADD_FIX[i], a, cy, acc_flags.h)) begin
                     found = 1'b1;
                     fix   = BCD_ADD_FIX[i];
                  end
               end
            end else if (last_kind == eba_pkg::KIND_SUB) begin
               for (int i = 0; i < 4; i++) begin
                  if (!found && bcd_row_hits(BCD_SUB_FIX[i], a, cy, acc_flags.h)) begin
                     found = 1'b1;
                     fix   = BCD_SUB_FIX[i];
                  end
               end
            end
            if (found) begin
               r8  = a + fix.delta;
               f.z = (r8 == 8'h00);
               f.h = 1'b0;
               f.c = fix.new_cy;
            end else begin
               // no row fits: flags stay, nothing is written back
               rp.writes_back  = 1'b0;
               rp.adjust_error = 1'b1;
            end
         end
         eba_pkg::OP_ADD16: begin
            sum17 = {1'b0, rq.operand_a} + {1'b0, rq.operand_b};
            low12 = {1'b0, rq.operand_a[11:0]} + {1'b0, rq.operand_b[11:0]};
            f.n   = 1'b0;
            f.h   = low12[12];
            f.c   = sum17[16];
         end
         default: rp.writes_back = 1'b0;   // opcode without meaning
      endcase
      rp.result = (rq.opcode == eba_pkg::OP_ADD16) ? sum17[15:0] : {8'h00, r8};
      rp.flags  = f;
      acc_flags = f;
      last_kind = kind;
      return rp;
   endfunction

   task automatic queue_req(logic [4:0] opcode, logic [15:0] a, logic [15:0] b,
                            logic [2:0] bit_index);
      req_pend_q.push_back('{opcode, a, b, bit_index});
   endtask

   // Favor the corner values of a byte.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h80;
         3: return 8'h7f;
         4: return 8'h0f;
         5: return 8'hf0;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_bcd();
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
   endfunction

   // Driver: present a new request once the last one is taken, with random
   // gaps between requests except near the end of the run.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (req_pend_q.size() > QuietTail && $urandom_range(0, 7) == 0) begin
               send_gap  <= $urandom_range(0, 13);
               req_valid <= 1'b0;
            end else if (req_pend_q.size() != 0) begin
               next_req      = req_pend_q.pop_front();
               req_valid     <= 1'b1;
               req_opcode    <= next_req.opcode;
               req_operand_a <= next_req.operand_a;
               req_operand_b <= next_req.operand_b;
               req_bit_index <= next_req.bit_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: stall in random bursts, none near the end of the run.
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_gap != 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (req_pend_q.size() > QuietTail && $urandom_range(0, 7) == 0) begin
            recv_gap  <= $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predict each accepted request and check each accepted response
   // against the oldest prediction. Count cycles without any handshake.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         acc_flags <= '0;
         last_kind <= eba_pkg::KIND_NONE;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            alu_expect_q.push_back(alu_predict('{req_opcode, req_operand_a,
                                                 req_operand_b, req_bit_index}));
         end
         if (rsp_valid && !rsp_stall) begin
            seen_rsp = '{rsp_result,
                         '{rsp_flag_zero, rsp_flag_subtract, rsp_flag_half, rsp_flag_carry},
                         rsp_writes_back, rsp_adjust_error};
            if (alu_expect_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < MaxReports) begin
                  $display("unexpected response: result %h znhc %b wb %b err %b",
                           seen_rsp.result, seen_rsp.flags, seen_rsp.writes_back,
                           seen_rsp.adjust_error);
               end
            end else begin
               want_rsp = alu_expect_q.pop_front();
               if (seen_rsp.result !== want_rsp.result || seen_rsp.flags !== want_rsp.flags ||
                   seen_rsp.writes_back !== want_rsp.writes_back ||
                   seen_rsp.adjust_error !== want_rsp.adjust_error) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < MaxReports) begin
                     $display("mismatch: exp %h znhc %b wb %b err %b, got %h znhc %b wb %b err %b",
                              want_rsp.result, want_rsp.flags, want_rsp.writes_back,
                              want_rsp.adjust_error, seen_rsp.result, seen_rsp.flags,
                              seen_rsp.writes_back, seen_rsp.adjust_error);
                  end
               end
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          n;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [4:0]  op;
      // Directed requests: corners of every operation and the special cases.
      queue_req(eba_pkg::OP_ADD,   16'hffff, 16'h5501, 3'd0);   // wraps to zero, H and CY
      queue_req(eba_pkg::OP_ADC,   16'h0000, 16'h0000, 3'd7);   // carry in from the add
      queue_req(eba_pkg::OP_ADD,   16'h0015, 16'h0027, 3'd0);
      queue_req(eba_pkg::OP_DAA,   16'h003c, 16'hffff, 3'd0);   // adjust after add
      queue_req(eba_pkg::OP_SUB,   16'h0010, 16'h0001, 3'd0);
      queue_req(eba_pkg::OP_DAA,   16'h000f, 16'h0000, 3'd0);   // adjust after subtract
      queue_req(eba_pkg::OP_SBC,   16'h0000, 16'h00ff, 3'd0);
      queue_req(eba_pkg::OP_AND,   16'h00ff, 16'hff00, 3'd0);
      queue_req(eba_pkg::OP_OR,    16'hff00, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_XOR,   16'h00ff, 16'h00ff, 3'd0);
      queue_req(eba_pkg::OP_CP,    16'h0042, 16'h0042, 3'd0);   // compare: no write back
      queue_req(eba_pkg::OP_INC,   16'h00ff, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_DEC,   16'h0000, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_RLC,   16'h0080, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_RL,    16'h0080, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_RRC,   16'h0001, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_RR,    16'h0001, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_SLA,   16'h0080, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_SRA,   16'h0081, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_SRL,   16'h0001, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_SWAP,  16'h00f0, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_BIT,   16'h0080, 16'h0000, 3'd7);   // bit test: no write back
      queue_req(eba_pkg::OP_SET,   16'hff00, 16'h0000, 3'd7);
      queue_req(eba_pkg::OP_RES,   16'h00ff, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_CPL,   16'h0000, 16'h0000, 3'd0);
      queue_req(eba_pkg::OP_DAA,   16'h0099, 16'h0000, 3'd0);   // previous op neither
      queue_req(eba_pkg::OP_ADD16, 16'hffff, 16'h0001, 3'd0);
      queue_req(5'd31,             16'hffff, 16'hffff, 3'd7);   // opcode without meaning
      queue_req(5'd24,             16'h0000, 16'h0000, 3'd0);

      // Random requests: BCD add/subtract followed by a decimal adjust,
      // 16-bit adds, and any operation on corner-heavy operands.
      n = 0;
      while (n < RandomItems) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               op = 5'($urandom_range(eba_pkg::OP_ADD, eba_pkg::OP_SBC));
               x  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : pick_bcd();
               y  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : pick_bcd();
               queue_req(op, {8'($urandom), x}, {8'($urandom), y}, 3'($urandom));
               if ($urandom_range(0, 15) == 0) begin
                  // break the pair: the adjust then finds no add or subtract
                  queue_req(eba_pkg::OP_SET, 16'($urandom), 16'($urandom), 3'($urandom));
                  n++;
               end
               x = (op == eba_pkg::OP_ADD || op == eba_pkg::OP_ADC) ? x + y : x - y;
               if ($urandom_range(0, 9) == 0) x = 8'($urandom);
               queue_req(eba_pkg::OP_DAA, {8'($urandom), x}, 16'($urandom), 3'($urandom));
               n += 2;
            end
            3: begin
               case ($urandom_range(0, 3))
                  0: queue_req(eba_pkg::OP_ADD16, 16'hffff, 16'($urandom), 3'($urandom));
                  1: queue_req(eba_pkg::OP_ADD16, 16'h0fff, 16'h0001, 3'($urandom));
                  default: queue_req(eba_pkg::OP_ADD16, 16'($urandom), 16'($urandom),
                                     3'($urandom));
               endcase
               n++;
            end
            default: begin
               op = ($urandom_range(0, 31) == 0)
                       ? 5'($urandom_range(24, 31))
                       : 5'($urandom_range(eba_pkg::OP_ADD, eba_pkg::OP_ADD16));
               queue_req(op, {8'($urandom), pick_byte()}, {8'($urandom), pick_byte()},
                         3'($urandom));
               n++;
            end
         endcase
      end

      // Hold reset, then release it on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every request is sent and every response has come back.
      while ((req_pend_q.size() != 0 || req_valid || alu_expect_q.size() != 0) &&
             idle_cycles < WatchdogLimit) begin
         @(negedge clock);
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("Simulation FAILED");
      end else begin
         // Let any stray response show up before the verdict.
         repeat (DrainCycles) @(negedge clock);
         if (fail_count == 0 && alu_expect_q.size() == 0) begin
            $display("Simulation PASSED");
         end else begin
            $display("Simulation FAILED");
         end
      end
      $finish;
   end

endmodule
